// ===== rtl/idpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpa_pkg
// Shared types and constants for the ID pool allocator: item layouts,
// command and status codes, pool sizing.
// ----------------------------------------------------------------------------
package idpa_pkg;

    // Pool sizing
    localparam int MAX_IDS = 256;
    localparam int ID_W    = $clog2(MAX_IDS);
    localparam int CNT_W   = $clog2(MAX_IDS + 1);

    // Command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_GROW    = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_USED  = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    // Input item
    typedef struct packed {
        logic [1:0]       command;
        logic [ID_W-1:0]  release_id;
        logic [CNT_W-1:0] target_count;
    } t_idpa_in;

    // Result item
    typedef struct packed {
        logic [ID_W-1:0]  granted_id;
        logic [1:0]       status;
        logic [CNT_W-1:0] pool_total;
    } t_idpa_out;

endpackage

// ===== rtl/id_pool_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_pool_allocator
// Free-list ID allocator: free IDs in a circular FIFO held in RAM, one
// in-use flag per ID in a second RAM.
// ----------------------------------------------------------------------------
// Takes one item at a time. Allocate waits for the registered read of the
// free-list RAM before the popped ID is known; release reads the in-use flag
// from its RAM before it is cleared; allocate on an empty pool and unknown
// commands are answered straight from the idle state; grow appends one ID per
// cycle, since the free-list RAM takes one write a cycle.
// A finished result sits in the output register while the next item is
// accepted; an item that finishes while that register is still full waits in
// a holding register until it drains. After reset a clearing pass zeroes all
// 256 in-use flags; no item is accepted until it ends.
module id_pool_allocator
    import idpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_idpa_in  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_idpa_out o_out_item
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_REL,
        S_GROW,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [ID_W-1:0]    r_clr, n_clr;
    logic [ID_W-1:0]    r_rel_id, n_rel_id;
    logic [CNT_W-1:0]   r_tgt, n_tgt;
    logic [1:0]         r_gstat, n_gstat;
    t_idpa_out          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_idpa_out          r_out, n_out;

    logic               mem_we;
    logic [ID_W-1:0]    mem_waddr;
    logic [ID_W-1:0]    mem_wdata;
    logic [ID_W-1:0]    mem_rdata;
    logic               mark_we;
    logic [ID_W-1:0]    mark_waddr;
    logic               mark_wdata;
    logic               mark_rdata;
    logic [ID_W-1:0]    tail;
    logic               out_free;
    logic               done;
    t_idpa_out          res;

    assign tail       = r_head + r_count[ID_W-1:0];
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Free-list storage, read address follows the head every cycle
    idpa_ram #(
        .DEPTH (MAX_IDS),
        .WIDTH (ID_W)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    // In-use flags, read address follows the offered release ID
    idpa_ram #(
        .DEPTH (MAX_IDS),
        .WIDTH (1)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (i_in_item.release_id),
        .o_rdata (mark_rdata)
    );

    // Command sequencing
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_total     = r_total;
        n_clr       = r_clr;
        n_rel_id    = r_rel_id;
        n_tgt       = r_tgt;
        n_gstat     = r_gstat;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = tail;
        mem_wdata   = '0;
        mark_we     = 1'b0;
        mark_waddr  = r_clr;
        mark_wdata  = 1'b0;
        done        = 1'b0;
        res         = '{granted_id: '0, status: ST_OK, pool_total: r_total};

        case (r_state)
            S_CLEAR: begin
                // zero one in-use flag per cycle
                mark_we = 1'b1;
                n_clr   = r_clr + 1'b1;
                if (r_clr == ID_W'(MAX_IDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.command)
                        CMD_ALLOC: begin
                            if (r_count == '0) begin
                                res.status = ST_EMPTY;
                                done       = 1'b1;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        CMD_RELEASE: begin
                            n_rel_id = i_in_item.release_id;
                            n_state  = S_REL;
                        end
                        CMD_GROW: begin
                            if (i_in_item.target_count > CNT_W'(MAX_IDS)) begin
                                n_tgt   = CNT_W'(MAX_IDS);
                                n_gstat = ST_SATURATED;
                            end else begin
                                n_tgt   = i_in_item.target_count;
                                n_gstat = ST_OK;
                            end
                            n_state = S_GROW;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                // popped ID arrives from the RAM now
                mark_we        = 1'b1;
                mark_waddr     = mem_rdata;
                mark_wdata     = 1'b1;
                n_head         = r_head + 1'b1;
                n_count        = r_count - 1'b1;
                res.granted_id = mem_rdata;
                done           = 1'b1;
            end
            S_REL: begin
                // in-use flag of the released ID arrives from the RAM now
                if (mark_rdata) begin
                    mark_we    = 1'b1;
                    mark_waddr = r_rel_id;
                    if (r_count < CNT_W'(MAX_IDS)) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rel_id;
                        n_count   = r_count + 1'b1;
                    end
                end else begin
                    res.status = ST_NOT_USED;
                end
                done = 1'b1;
            end
            S_GROW: begin
                // one new ID appended per cycle
                if (r_total < r_tgt) begin
                    if (r_count < CNT_W'(MAX_IDS)) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_total[ID_W-1:0];
                        n_count   = r_count + 1'b1;
                    end
                    n_total = r_total + 1'b1;
                end else begin
                    res.status = r_gstat;
                    done       = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or hold it
        if (done) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = res;
                n_state     = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_DONE;
            end
        end
    end

    // State and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_total     <= n_total;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_rel_id <= n_rel_id;
        r_tgt    <= n_tgt;
        r_gstat  <= n_gstat;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/idpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module idpa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
